@@ hdl/exst_pkg.sv @@
package exst_pkg;

	localparam int unsigned DataWidth = 64;

	// instruction codes
	typedef enum logic [3:0] {
		IC_HALT   = 4'd0,
		IC_NOP    = 4'd1,
		IC_RRMOVQ = 4'd2,
		IC_IRMOVQ = 4'd3,
		IC_RMMOVQ = 4'd4,
		IC_MRMOVQ = 4'd5,
		IC_OPQ    = 4'd6,
		IC_JXX    = 4'd7,
		IC_CALL   = 4'd8,
		IC_RET    = 4'd9,
		IC_PUSHQ  = 4'd10,
		IC_POPQ   = 4'd11
	} icode_t;

	// alu function codes
	localparam logic [3:0] ALU_ADD = 4'd0;
	localparam logic [3:0] ALU_SUB = 4'd1;
	localparam logic [3:0] ALU_AND = 4'd2;
	localparam logic [3:0] ALU_XOR = 4'd3;

	// condition selectors
	localparam logic [3:0] CND_ALWAYS = 4'd0;
	localparam logic [3:0] CND_LE     = 4'd1;
	localparam logic [3:0] CND_L      = 4'd2;
	localparam logic [3:0] CND_E      = 4'd3;
	localparam logic [3:0] CND_NE     = 4'd4;
	localparam logic [3:0] CND_GE     = 4'd5;
	localparam logic [3:0] CND_G      = 4'd6;

	// status codes
	localparam logic [2:0] STAT_BUB = 3'd0;
	localparam logic [2:0] STAT_AOK = 3'd1;
	localparam logic [2:0] STAT_HLT = 3'd2;
	localparam logic [2:0] STAT_ADR = 3'd3;
	localparam logic [2:0] STAT_INS = 3'd4;

	localparam logic [3:0] REG_NONE = 4'hf;

	typedef struct packed {
		logic        insert_bubble;
		logic [2:0]  in_status;
		logic [3:0]  in_icode;
		logic [3:0]  in_ifun;
		logic [63:0] const_value;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
		logic [3:0]  in_dest_e;
		logic [3:0]  in_dest_m;
		logic [2:0]  mem_status;
		logic [2:0]  wb_status;
	} item_t;

	typedef struct packed {
		logic [2:0]  out_status;
		logic [3:0]  out_icode;
		logic [3:0]  out_ifun;
		logic        cond_true;
		logic [63:0] exec_value;
		logic [63:0] pass_value_a;
		logic [3:0]  out_dest_e;
		logic [3:0]  out_dest_m;
		logic [63:0] fwd_value;
		logic [3:0]  fwd_dest;
	} result_t;

endpackage

@@ hdl/y86_execute_stage.sv @@
// channel  | valid        | stall         | payload
// ---------+--------------+---------------+------------------
// item     | item_valid   | item_stall    | item   (item_t)
// result   | result_valid | result_stall  | result (result_t)
//
// the path from item request to result: input register, then the alu and
// condition logic into the result register. one item per cycle sustained while result_stall is low.
// flags update for an unsquashed opq item with a known alu function on the edge
// it moves into the result register, so the next item sees them in its own compute cycle.
// reset: flags zf=1 sf=0 of=0, both stages empty.
// result_stall backs up into item_stall only when both stages are full.
module y86_execute_stage #(
	parameter int unsigned WORD_WIDTH = exst_pkg::DataWidth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  exst_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_stall,
	output exst_pkg::result_t result
);

	localparam int unsigned W = WORD_WIDTH;

	// input stage
	logic         valid_s1;
	logic [2:0]   stat_s1;
	logic [3:0]   icode_s1;
	logic [3:0]   ifun_s1;
	logic [W-1:0] vc_s1;
	logic [W-1:0] va_s1;
	logic [W-1:0] vb_s1;
	logic [3:0]   dste_s1;
	logic [3:0]   dstm_s1;
	logic [2:0]   mstat_s1;
	logic [2:0]   wstat_s1;

	logic         zf_q;
	logic         sf_q;
	logic         of_q;

	logic         valid_s2;
	exst_pkg::result_t res_s2;

	logic         s2_ready;
	logic         advance;
	logic         load_s1;

	logic         cnd;
	logic         lt;
	logic         squash;
	logic         write_flags;
	logic [W-1:0] ve;
	logic         new_of;
	logic [3:0]   dste_sel;
	exst_pkg::result_t res_next;

	assign s2_ready   = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && s2_ready;
	assign item_stall = valid_s1 && !s2_ready;
	assign load_s1    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// bubble replacement happens on capture
	always_ff @(posedge clk) begin
		if (load_s1) begin
			mstat_s1 <= item.mem_status;
			wstat_s1 <= item.wb_status;
			if (item.insert_bubble) begin
				stat_s1  <= exst_pkg::STAT_BUB;
				icode_s1 <= exst_pkg::IC_NOP;
				ifun_s1  <= 4'd0;
				vc_s1    <= '0;
				va_s1    <= '0;
				vb_s1    <= '0;
				dste_s1  <= exst_pkg::REG_NONE;
				dstm_s1  <= exst_pkg::REG_NONE;
			end else begin
				stat_s1  <= item.in_status;
				icode_s1 <= item.in_icode;
				ifun_s1  <= item.in_ifun;
				vc_s1    <= item.const_value[W-1:0];
				va_s1    <= item.operand_a[W-1:0];
				vb_s1    <= item.operand_b[W-1:0];
				dste_s1  <= item.in_dest_e;
				dstm_s1  <= item.in_dest_m;
			end
		end
	end

	always_comb begin
		lt = sf_q ^ of_q;
		case (ifun_s1)
			exst_pkg::CND_ALWAYS: cnd = 1'b1;
			exst_pkg::CND_LE:     cnd = lt || zf_q;
			exst_pkg::CND_L:      cnd = lt;
			exst_pkg::CND_E:      cnd = zf_q;
			exst_pkg::CND_NE:     cnd = !zf_q;
			exst_pkg::CND_GE:     cnd = !lt;
			exst_pkg::CND_G:      cnd = !lt && !zf_q;
			default:              cnd = 1'b0;
		endcase
	end

	always_comb begin
		ve          = '0;
		new_of      = 1'b0;
		write_flags = 1'b0;
		case (icode_s1)
			exst_pkg::IC_RRMOVQ: ve = va_s1;
			exst_pkg::IC_IRMOVQ: ve = vc_s1;
			exst_pkg::IC_RMMOVQ,
			exst_pkg::IC_MRMOVQ: ve = vc_s1 + vb_s1;
			exst_pkg::IC_CALL,
			exst_pkg::IC_PUSHQ:  ve = vb_s1 - W'(8);
			exst_pkg::IC_RET,
			exst_pkg::IC_POPQ:   ve = vb_s1 + W'(8);
			exst_pkg::IC_OPQ: begin
				write_flags = 1'b1;
				case (ifun_s1)
					exst_pkg::ALU_ADD: begin
						ve     = va_s1 + vb_s1;
						new_of = (va_s1[W-1] == vb_s1[W-1]) && (ve[W-1] != va_s1[W-1]);
					end
					exst_pkg::ALU_SUB: begin
						ve     = vb_s1 - va_s1;
						new_of = (va_s1[W-1] != vb_s1[W-1]) && (ve[W-1] != vb_s1[W-1]);
					end
					exst_pkg::ALU_AND: ve = va_s1 & vb_s1;
					exst_pkg::ALU_XOR: ve = va_s1 ^ vb_s1;
					default:           write_flags = 1'b0;
				endcase
			end
			default: ve = '0;
		endcase
	end

	always_comb begin
		squash = (mstat_s1 inside {exst_pkg::STAT_HLT, exst_pkg::STAT_ADR,
			exst_pkg::STAT_INS}) ||
			(wstat_s1 inside {exst_pkg::STAT_HLT, exst_pkg::STAT_ADR,
			exst_pkg::STAT_INS});
		// failed cmov drops its destination
		dste_sel = (icode_s1 == exst_pkg::IC_RRMOVQ && !cnd) ? exst_pkg::REG_NONE : dste_s1;

		res_next.fwd_value = 64'(ve);
		res_next.fwd_dest  = dste_sel;
		if (squash) begin
			res_next.out_status   = exst_pkg::STAT_BUB;
			res_next.out_icode    = exst_pkg::IC_NOP;
			res_next.out_ifun     = 4'd0;
			res_next.cond_true    = 1'b0;
			res_next.exec_value   = '0;
			res_next.pass_value_a = '0;
			res_next.out_dest_e   = exst_pkg::REG_NONE;
			res_next.out_dest_m   = exst_pkg::REG_NONE;
		end else begin
			res_next.out_status   = stat_s1;
			res_next.out_icode    = icode_s1;
			res_next.out_ifun     = ifun_s1;
			res_next.cond_true    = cnd;
			res_next.exec_value   = 64'(ve);
			res_next.pass_value_a = 64'(va_s1);
			res_next.out_dest_e   = dste_sel;
			res_next.out_dest_m   = dstm_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zf_q <= 1'b1;
			sf_q <= 1'b0;
			of_q <= 1'b0;
		end else if (advance && write_flags && !squash) begin
			zf_q <= (ve == '0);
			sf_q <= ve[W-1];
			of_q <= new_of;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result_valid = valid_s2;
	assign result       = res_s2;

	a_squash_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		advance && squash |=> $stable({zf_q, sf_q, of_q}))
		else $error("flags written under downstream exception");

	a_squash_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		advance && squash |=> result.out_icode == exst_pkg::IC_NOP &&
			result.exec_value == '0 && result.out_dest_e == exst_pkg::REG_NONE)
		else $error("squashed item not turned into a bubble");

	a_logic_clears_of: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !squash && icode_s1 == exst_pkg::IC_OPQ &&
			(ifun_s1 == exst_pkg::ALU_AND || ifun_s1 == exst_pkg::ALU_XOR) |=> !of_q)
		else $error("and/xor left overflow set");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && valid_s2)
		else $error("item stalled with a free stage");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage lost an item");

endmodule
